// ===== sv/kt_pkg.sv =====
// Shared types and constants for the keyword tokenizer.
package kt_pkg;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUMBER  = 3'd1,
        MODE_WORD    = 3'd2,
        MODE_STRING  = 3'd3,
        MODE_STOPPED = 3'd4,
        MODE_ENDED   = 3'd5
    } scan_mode_t;

    // Token kinds
    localparam logic [4:0] KIND_CHAR      = 5'd0;
    localparam logic [4:0] KIND_LPAREN    = 5'd1;
    localparam logic [4:0] KIND_RPAREN    = 5'd2;
    localparam logic [4:0] KIND_COMMA     = 5'd3;
    localparam logic [4:0] KIND_SEMI      = 5'd4;
    localparam logic [4:0] KIND_EQUAL     = 5'd5;
    localparam logic [4:0] KIND_INT       = 5'd6;
    localparam logic [4:0] KIND_IDENT     = 5'd7;
    localparam logic [4:0] KIND_STRING    = 5'd8;
    localparam logic [4:0] KIND_LET       = 5'd9;
    localparam logic [4:0] KIND_DONE      = 5'd14;
    localparam logic [4:0] KIND_BAD       = 5'd15;
    localparam logic [4:0] KIND_EARLY_END = 5'd16;

    // Character codes
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_EQUAL   = 8'h3D;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_TAB     = 8'h09;

    localparam logic [30:0] INT_MAX31 = 31'h7FFF_FFFF;

    // Number of result bundles the queue holds
    localparam int QUEUE_DEPTH = 4;

    // Position-independent part of one result
    typedef struct packed {
        logic [4:0]  kind;
        logic [30:0] value;
        logic        ovf;
    } token_t;

    localparam int TOKEN_W = $bits(token_t);

endpackage

// ===== sv/kt_front.sv =====
// Front end: accepts characters, runs the scanner and builds result bundles.
module kt_front
    import kt_pkg::*;
#(
    parameter int POSITION_WIDTH = 24,
    localparam int RES_W = TOKEN_W + 2 * POSITION_WIDTH,
    localparam int BUNDLE_W = 2 + 2 * RES_W
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          char_byte,
    input  logic                end_of_input,
    output logic                push,
    output logic [BUNDLE_W-1:0] bundle
);

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
    localparam logic [POSITION_WIDTH-1:0] POS_ONE = POSITION_WIDTH'(1);

    // Keyword text, right aligned: let, in, if, then, else
    localparam logic [4:0][31:0] KW_TEXT = '{"else", "then", "if", "in", "let"};
    localparam logic [4:0][2:0]  KW_LEN  = '{3'd4, 3'd4, 3'd2, 3'd2, 3'd3};

    // Drop keywords that no longer match after character c at offset len
    function automatic logic [4:0] kw_filter(input logic [4:0] cand, input logic [2:0] len,
                                             input logic [7:0] c);
        logic [4:0] keep;
        logic [2:0] diff;
        logic [7:0] ch;
        keep = cand;
        for (int k = 0; k < 5; k++) begin
            diff = KW_LEN[k] - 3'd1 - len;
            ch   = KW_TEXT[k][{diff[1:0], 3'b000} +: 8];
            if (len >= KW_LEN[k] || ch != c) begin
                keep[k] = 1'b0;
            end
        end
        return keep;
    endfunction

    function automatic logic [RES_W-1:0] mk_res(input logic [4:0] kind, input logic [30:0] value,
                                                input logic ovf,
                                                input logic [POSITION_WIDTH-1:0] ln,
                                                input logic [POSITION_WIDTH-1:0] col);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.ovf   = ovf;
        return {t, ln, col};
    endfunction

    scan_mode_t                mode_reg, mode_next;
    logic [30:0]               acc_reg, acc_next;
    logic                      sat_reg, sat_next;
    logic [4:0]                cand_reg, cand_next;
    logic [2:0]                len_reg, len_next;
    logic [POSITION_WIDTH-1:0] line_reg, line_next;
    logic [POSITION_WIDTH-1:0] col_reg, col_next;

    logic                      accept, active;
    logic                      is_digit, is_alpha, is_ws, is_quote, is_punct;
    logic [4:0]                punct_kind;
    logic [3:0]                digit_val;
    logic [34:0]               acc_ext, acc_mul;
    logic                      sat_hit;
    logic [POSITION_WIDTH-1:0] line_adv, col_adv;
    logic [4:0]                cand_word, cand_start;
    logic [2:0]                len_inc;
    logic [4:0]                close_kind;
    scan_mode_t                idle_mode;
    logic                      idle_has;
    logic [4:0]                idle_kind;
    logic [30:0]               idle_value;
    logic [RES_W-1:0]          res0, res1, idle_res;
    logic [1:0]                res_n;

    assign accept = in_valid && in_ready;
    assign active = (mode_reg != MODE_STOPPED) && (mode_reg != MODE_ENDED);

    // Classify the character and precompute the datapath updates
    always_comb begin
        is_digit  = (char_byte >= "0") && (char_byte <= "9");
        is_alpha  = ((char_byte >= "a") && (char_byte <= "z")) ||
                    ((char_byte >= "A") && (char_byte <= "Z")) || (char_byte == "_");
        is_ws     = (char_byte == CH_SPACE) || (char_byte == CH_TAB) ||
                    (char_byte == CH_NEWLINE);
        is_quote  = (char_byte == CH_QUOTE);
        is_punct  = 1'b1;
        case (char_byte)
            CH_LPAREN: punct_kind = KIND_LPAREN;
            CH_RPAREN: punct_kind = KIND_RPAREN;
            CH_COMMA:  punct_kind = KIND_COMMA;
            CH_SEMI:   punct_kind = KIND_SEMI;
            CH_EQUAL:  punct_kind = KIND_EQUAL;
            default: begin
                punct_kind = KIND_CHAR;
                is_punct   = 1'b0;
            end
        endcase
        digit_val = char_byte[3:0];

        // accumulator * 10 + digit, saturating at the largest 31-bit value
        acc_ext = {4'b0000, acc_reg};
        acc_mul = (acc_ext << 3) + (acc_ext << 1) + {31'd0, digit_val};
        sat_hit = acc_mul > {4'b0000, INT_MAX31};

        // position after this character
        line_adv = line_reg;
        col_adv  = col_reg;
        if (char_byte == CH_NEWLINE) begin
            if (line_reg != POS_MAX) begin
                line_adv = line_reg + POS_ONE;
            end
            col_adv = '0;
        end else if (col_reg != POS_MAX) begin
            col_adv = col_reg + POS_ONE;
        end

        cand_word  = kw_filter(cand_reg, len_reg, char_byte);
        cand_start = kw_filter(5'h1F, 3'd0, char_byte);
        len_inc    = (len_reg == 3'd7) ? 3'd7 : len_reg + 3'd1;

        // closing kind: first keyword still matching at full length
        close_kind = KIND_IDENT;
        for (int k = 4; k >= 0; k--) begin
            if (cand_reg[k] && KW_LEN[k] == len_reg) begin
                close_kind = KIND_LET + 5'(k);
            end
        end

        // character seen in idle mode
        if (is_quote) begin
            idle_mode = MODE_STRING;
        end else if (is_digit) begin
            idle_mode = MODE_NUMBER;
        end else if (is_alpha) begin
            idle_mode = MODE_WORD;
        end else if (is_punct || is_ws) begin
            idle_mode = MODE_IDLE;
        end else begin
            idle_mode = MODE_STOPPED;
        end
        idle_has   = is_punct || is_alpha || !(is_quote || is_ws || is_digit);
        idle_kind  = is_punct ? punct_kind : (is_alpha ? KIND_CHAR : KIND_BAD);
        idle_value = is_alpha ? {23'd0, char_byte} : 31'd0;
    end

    // Next scanner state
    always_comb begin
        logic apply_idle;
        logic adv;
        apply_idle = 1'b0;
        adv        = 1'b0;
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        cand_next  = cand_reg;
        len_next   = len_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        if (accept && active) begin
            if (end_of_input) begin
                mode_next = (mode_reg == MODE_STRING) ? MODE_STOPPED : MODE_ENDED;
            end else begin
                unique case (mode_reg)
                    MODE_STRING: begin
                        if (is_quote) begin
                            mode_next = MODE_IDLE;
                        end
                        adv = 1'b1;
                    end
                    MODE_NUMBER: begin
                        if (is_digit) begin
                            acc_next = sat_hit ? INT_MAX31 : acc_mul[30:0];
                            sat_next = sat_reg || sat_hit;
                            adv      = 1'b1;
                        end else if (is_alpha) begin
                            mode_next = MODE_STOPPED;
                        end else begin
                            apply_idle = 1'b1;
                        end
                    end
                    MODE_WORD: begin
                        if (is_digit || is_alpha) begin
                            cand_next = cand_word;
                            len_next  = len_inc;
                            adv       = 1'b1;
                        end else begin
                            apply_idle = 1'b1;
                        end
                    end
                    MODE_IDLE: begin
                        apply_idle = 1'b1;
                    end
                    default: ;
                endcase
                if (apply_idle) begin
                    mode_next = idle_mode;
                    if (is_digit) begin
                        acc_next = {27'd0, digit_val};
                        sat_next = 1'b0;
                    end
                    if (is_alpha) begin
                        cand_next = cand_start;
                        len_next  = 3'd1;
                    end
                    adv = (idle_mode != MODE_STOPPED);
                end
                if (adv) begin
                    line_next = line_adv;
                    col_next  = col_adv;
                end
            end
        end
    end

    // Results caused by this item
    always_comb begin
        idle_res = mk_res(idle_kind, idle_value, 1'b0, line_reg, col_reg);
        res0     = '0;
        res1     = '0;
        res_n    = 2'd0;
        if (active) begin
            if (end_of_input) begin
                unique case (mode_reg)
                    MODE_STRING: begin
                        res0  = mk_res(KIND_EARLY_END, 31'd0, 1'b0, '0, '0);
                        res_n = 2'd1;
                    end
                    MODE_NUMBER: begin
                        res0  = mk_res(KIND_INT, acc_reg, sat_reg, line_reg, col_reg);
                        res1  = mk_res(KIND_DONE, 31'd0, 1'b0, line_reg, col_reg);
                        res_n = 2'd2;
                    end
                    MODE_WORD: begin
                        res0  = mk_res(close_kind, 31'd0, 1'b0, line_reg, col_reg);
                        res1  = mk_res(KIND_DONE, 31'd0, 1'b0, line_reg, col_reg);
                        res_n = 2'd2;
                    end
                    default: begin
                        res0  = mk_res(KIND_DONE, 31'd0, 1'b0, line_reg, col_reg);
                        res_n = 2'd1;
                    end
                endcase
            end else begin
                unique case (mode_reg)
                    MODE_STRING: begin
                        if (is_quote) begin
                            res0 = mk_res(KIND_STRING, 31'd0, 1'b0, line_adv, col_adv);
                        end else begin
                            res0 = mk_res(KIND_CHAR, {23'd0, char_byte}, 1'b0,
                                          line_reg, col_reg);
                        end
                        res_n = 2'd1;
                    end
                    MODE_NUMBER: begin
                        if (is_digit) begin
                            res_n = 2'd0;
                        end else if (is_alpha) begin
                            res0  = mk_res(KIND_BAD, 31'd0, 1'b0, line_reg, col_reg);
                            res_n = 2'd1;
                        end else begin
                            res0  = mk_res(KIND_INT, acc_reg, sat_reg, line_reg, col_reg);
                            res1  = idle_res;
                            res_n = idle_has ? 2'd2 : 2'd1;
                        end
                    end
                    MODE_WORD: begin
                        if (is_digit || is_alpha) begin
                            res0  = mk_res(KIND_CHAR, {23'd0, char_byte}, 1'b0,
                                           line_reg, col_reg);
                            res_n = 2'd1;
                        end else begin
                            res0  = mk_res(close_kind, 31'd0, 1'b0, line_reg, col_reg);
                            res1  = idle_res;
                            res_n = idle_has ? 2'd2 : 2'd1;
                        end
                    end
                    default: begin
                        res0  = idle_res;
                        res_n = idle_has ? 2'd1 : 2'd0;
                    end
                endcase
            end
        end
    end

    assign push   = accept && (res_n != 2'd0);
    assign bundle = {res_n, res1, res0};

    // Scanner state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            sat_reg  <= 1'b0;
            cand_reg <= 5'h1F;
            len_reg  <= '0;
            line_reg <= POS_ONE;
            col_reg  <= '0;
        end else begin
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            sat_reg  <= sat_next;
            cand_reg <= cand_next;
            len_reg  <= len_next;
            line_reg <= line_next;
            col_reg  <= col_next;
        end
    end

endmodule

// ===== sv/kt_queue.sv =====
// Short bundle queue between the scanner and the output stage.
module kt_queue
    import kt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the item
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/kt_back.sv =====
// Back end: splits each bundle into one or two result items on the output channel.
module kt_back
    import kt_pkg::*;
#(
    parameter int POSITION_WIDTH = 24,
    localparam int RES_W = TOKEN_W + 2 * POSITION_WIDTH,
    localparam int BUNDLE_W = 2 + 2 * RES_W,
    localparam int TDATA_W = ((32 + 2 * POSITION_WIDTH + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  logic [BUNDLE_W-1:0] head,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [TDATA_W-1:0]  m_tdata,
    output logic [4:0]          m_tuser,
    output logic                m_tlast
);

    logic                      sub_reg, sub_next;
    logic [1:0]                res_n;
    logic [RES_W-1:0]          res;
    token_t                    tok;
    logic [POSITION_WIDTH-1:0] ln, col;
    logic                      take;

    // Pick the current result of the head bundle
    always_comb begin
        res_n = head[BUNDLE_W-1 -: 2];
        res   = sub_reg ? head[2*RES_W-1 -: RES_W] : head[RES_W-1:0];
        tok   = token_t'(res[RES_W-1 -: TOKEN_W]);
        ln    = res[2*POSITION_WIDTH-1 -: POSITION_WIDTH];
        col   = res[POSITION_WIDTH-1:0];
    end

    assign m_tvalid = head_valid;
    assign m_tlast  = (res_n != 2'd2) || sub_reg;
    assign m_tuser  = tok.kind;
    assign m_tdata  = TDATA_W'({col, ln, tok.ovf, tok.value});
    assign take     = m_tvalid && m_tready;
    assign pop      = take && m_tlast;

    // Step to the second result, or back to the first on the bundle's last item
    always_comb begin
        sub_next = sub_reg;
        if (take) begin
            sub_next = !m_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sub_reg <= 1'b0;
        end else begin
            sub_reg <= sub_next;
        end
    end

endmodule

// ===== sv/keyword_tokenizer.sv =====
// Top level of the keyword tokenizer: scanner, bundle queue and output stage.
//
// Input channel s_*: one item per character, s_tdata[7:0] the byte, s_tlast set
// marks end of input (the byte is then ignored). Output channel m_*: one item per
// token or streamed character, m_tuser the token kind, m_tlast set on the last
// item caused by one input item.
// Each input's items are written into the queue as one bundle and appear on m_* from
// there; the second item, if any, follows as soon as the first is taken.
// Throughput: one input item per cycle while the queue has space. The scanner updates
// all its state in the cycle of acceptance; the output port moves one item per cycle
// while m_tready is high, and a four-entry queue absorbs inputs that cause two items.
// When the receiver stalls, the queue fills and s_tready drops until space frees.
// Reset (aresetn low, synchronous) empties the queue and returns the scanner to
// idle at line 1, column 0. After end of input or an error, inputs are still
// taken but cause no items until the next reset.
module keyword_tokenizer
    import kt_pkg::*;
#(
    parameter int POSITION_WIDTH = 24,
    localparam int RES_W = TOKEN_W + 2 * POSITION_WIDTH,
    localparam int BUNDLE_W = 2 + 2 * RES_W,
    localparam int TDATA_W = ((32 + 2 * POSITION_WIDTH + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,   // char_byte
    input  logic               s_tlast,   // end_of_input
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [TDATA_W-1:0] m_tdata,   // token_value, overflow, line_number, column_number
    output logic [4:0]         m_tuser,   // token_kind
    output logic               m_tlast    // last
);

    logic                push;
    logic [BUNDLE_W-1:0] wbundle, rbundle;
    logic                q_full, q_empty, pop;

    assign s_tready = !q_full;

    kt_front #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .char_byte   (s_tdata),
        .end_of_input(s_tlast),
        .push        (push),
        .bundle      (wbundle)
    );

    kt_queue #(
        .WIDTH(BUNDLE_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (push),
        .wdata  (wbundle),
        .full   (q_full),
        .pop    (pop),
        .rdata  (rbundle),
        .empty  (q_empty)
    );

    kt_back #(
        .POSITION_WIDTH(POSITION_WIDTH)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(!q_empty),
        .head      (rbundle),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef NO_ASSERTIONS
    // Done and error items always close their input's results
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_DONE || m_tuser == KIND_BAD ||
                     m_tuser == KIND_EARLY_END) |-> m_tlast)
        else $error("done or error item without tlast");

    // Nothing follows the done item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tuser == KIND_DONE |=> !m_tvalid)
        else $error("item after done");

    // The first of a pair is followed at once by the closing item
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tlast)
        else $error("second item of a pair missing");
`endif

endmodule
